/* rtl/knns_pkg.sv */
// Package for k_nearest_node_select: payload structs, sizes, mode codes, FSM states.
// No dependencies.
package knns_pkg;
    localparam int NodeMax = 1024;
    localparam int IdxW = 10;
    localparam int CntW = 11;
    localparam int KMax = 16;
    localparam int DistW = 34;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [10:0]        exclude_index;
    } t_in;

    typedef struct packed {
        logic [9:0] neighbor_index;
        logic       found;
        logic       last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;
endpackage

/* rtl/knns_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module knns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/k_nearest_node_select.sv */
// Top level of k_nearest_node_select: point store and k-nearest-neighbor scanner.
// Depends on knns_pkg and knns_ram.
//
// Usage: input transactions on i_in_valid/o_in_ready carry a mode, a point and
// an exclude index. Clear and append produce nothing, so appends stream one
// point per cycle while the block is idle. A query makes one pass over the
// stored points for every neighbor it returns: each pass reads the point
// memory once per entry (one read port with a registered read, then a
// registered multiply and a registered sum) and then presents one result.
// The number of passes is k = neighbors_wanted clamped to 1..16 and to the
// number of stored points other than the excluded one. Results leave on
// o_out_valid/i_out_ready, nearest first, the final one flagged last; a
// query with no candidate gives one result with found=0. While the
// receiver stalls, the result register holds and the next pass waits.
// Reset (synchronous, i_rst_n low) empties the set and sets neighbors_wanted
// to 8; memory contents stay undefined, which is harmless since only
// indices below the count are used. i_cfg_we writes the register at once;
// the user must assert it only while the block is idle, since the block
// itself does not enforce this.
module k_nearest_node_select (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  knns_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output knns_pkg::t_out  o_out
);
    localparam int IW = knns_pkg::IdxW;
    localparam int CW = knns_pkg::CntW;
    localparam int DW = knns_pkg::DistW;

    knns_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_count;
    logic [4:0]     r_want;
    logic [4:0]     r_k, r_n;
    logic signed [15:0] r_qx, r_qy;
    logic [CW-1:0]  r_excl;
    logic [CW-1:0]  r_cand;
    logic [CW-1:0]  r_rd_idx;
    // Pipeline: stage 1 = memory data valid, stage 2 = squares, stage 3 = sum.
    logic           r_v1, r_v2, r_v3;
    logic [IW-1:0]  r_i1, r_i2, r_i3;
    logic [31:0]    r_sqx, r_sqy;
    logic [DW-1:0]  r_d3;
    logic           r_have_prev, r_got;
    logic [DW-1:0]  r_prev_d, r_best_d;
    logic [IW-1:0]  r_prev_i, r_best_i;
    knns_pkg::t_out r_out;
    logic           r_out_valid;

    logic signed [15:0] mem_x, mem_y;
    logic           in_fire, we;
    logic           issue;
    logic signed [16:0] dx, dy;
    logic           take;
    logic           done_pick;

    assign o_in_ready  = (r_state == knns_pkg::ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign we          = in_fire && (i_in.mode == knns_pkg::MODE_APPEND)
                         && (r_count < CW'(knns_pkg::NodeMax));
    assign issue       = (r_state == knns_pkg::ST_SCAN);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The pick being presented is the final one when nothing was found, when
    // the wanted count is reached, or when every candidate has been listed.
    assign done_pick   = !r_got || (r_n + 5'd1 >= r_k)
                         || (CW'(r_n) + CW'(1) >= r_cand);

    knns_ram #(.WIDTH(16), .DEPTH(knns_pkg::NodeMax)) u_ram_x (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_count[IW-1:0]), .i_wdata(i_in.x),
        .i_raddr(r_rd_idx[IW-1:0]), .o_rdata(mem_x)
    );
    knns_ram #(.WIDTH(16), .DEPTH(knns_pkg::NodeMax)) u_ram_y (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_count[IW-1:0]), .i_wdata(i_in.y),
        .i_raddr(r_rd_idx[IW-1:0]), .o_rdata(mem_y)
    );

    assign dx = 17'(r_qx) - 17'(mem_x);
    assign dy = 17'(r_qy) - 17'(mem_y);

    // A candidate qualifies if it lies strictly after the previous pick in
    // (distance, index) order and beats the best so far. Indices arrive in
    // ascending order, so a strict less-than keeps the lower index on ties.
    always_comb begin
        take = r_v3 && (r_have_prev == 1'b0 || r_d3 > r_prev_d
                || (r_d3 == r_prev_d && r_i3 > r_prev_i))
                && (!r_got || r_d3 < r_best_d);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            knns_pkg::ST_IDLE: begin
                if (in_fire && i_in.mode == knns_pkg::MODE_QUERY) begin
                    n_state = knns_pkg::ST_SCAN;
                end
            end
            knns_pkg::ST_SCAN: begin
                if (r_rd_idx >= r_count) begin
                    n_state = knns_pkg::ST_DRAIN;
                end
            end
            knns_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = knns_pkg::ST_EMIT;
                end
            end
            knns_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (done_pick) begin
                        n_state = knns_pkg::ST_IDLE;
                    end else begin
                        n_state = knns_pkg::ST_SCAN;
                    end
                end
            end
            default: n_state = knns_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= knns_pkg::ST_IDLE;
            r_count     <= '0;
            r_want      <= 5'd8;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_want <= i_cfg_wdata;
            end
            if (in_fire && i_in.mode == knns_pkg::MODE_CLEAR) begin
                r_count <= '0;
            end
            if (we) begin
                r_count <= r_count + CW'(1);
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= issue && (r_rd_idx < r_count) && (r_rd_idx != r_excl);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_state == knns_pkg::ST_EMIT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= r_rd_idx[IW-1:0];
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_sqx <= 32'(dx * dx);
        r_sqy <= 32'(dy * dy);
        r_d3  <= DW'(r_sqx) + DW'(r_sqy);
        if (issue) begin
            r_rd_idx <= r_rd_idx + CW'(1);
        end
        if (take) begin
            r_got    <= 1'b1;
            r_best_d <= r_d3;
            r_best_i <= r_i3;
        end
        if (in_fire && i_in.mode == knns_pkg::MODE_QUERY) begin
            r_qx        <= i_in.x;
            r_qy        <= i_in.y;
            r_excl      <= i_in.exclude_index;
            r_cand      <= (i_in.exclude_index < r_count) ? r_count - CW'(1) : r_count;
            r_rd_idx    <= '0;
            r_got       <= 1'b0;
            r_have_prev <= 1'b0;
            r_n         <= '0;
            if (r_want == 5'd0) begin
                r_k <= 5'd1;
            end else if (r_want > 5'(knns_pkg::KMax)) begin
                r_k <= 5'(knns_pkg::KMax);
            end else begin
                r_k <= r_want;
            end
        end
        if (r_state == knns_pkg::ST_EMIT && (!r_out_valid || i_out_ready)) begin
            r_out.neighbor_index <= r_got ? r_best_i : '0;
            r_out.found          <= r_got;
            r_out.last           <= done_pick;
            r_have_prev          <= 1'b1;
            r_prev_d             <= r_best_d;
            r_prev_i             <= r_best_i;
            r_got                <= 1'b0;
            r_rd_idx             <= '0;
            r_n                  <= r_n + 5'd1;
        end
    end
endmodule
